// File: design/bsb_pkg.sv
package bsb_pkg;

  // default store geometry
  localparam int DEF_MAX_TEX_WIDTH    = 256;
  localparam int DEF_MAX_TEX_HEIGHT   = 256;
  localparam int DEF_MAX_BRUSH_WIDTH  = 64;
  localparam int DEF_MAX_BRUSH_HEIGHT = 64;

  // field widths
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // register indexes on the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TEX_WIDTH,
    REG_TEX_HEIGHT,
    REG_TEX_CHANNELS,
    REG_BRUSH_WIDTH,
    REG_BRUSH_HEIGHT,
    REG_BRUSH_CHANNELS,
    REG_BRUSH_SCALE
  } reg_index_t;

  // item actions
  typedef enum logic [1:0] {
    ACT_TEX_WRITE,
    ACT_BRUSH_WRITE,
    ACT_PAINT,
    ACT_READ
  } action_t;

  // shared arithmetic unit operations
  typedef enum logic [1:0] {
    ARITH_MUL,
    ARITH_DIV,
    ARITH_SQRT
  } arith_op_t;

  typedef struct packed {
    logic        start;
    arith_op_t   op;
    logic [63:0] a;      // multiplicand (low half), dividend or radicand
    logic [31:0] b;      // multiplier or divisor
    logic [4:0]  qbits;  // quotient bits for a divide
  } arith_req_t;

  typedef struct packed {
    logic        idle;
    logic        done;
    logic [63:0] res;
  } arith_rsp_t;

endpackage

// File: design/bsb_if.sv
interface bsb_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface bsb_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  coord_x;
  logic [7:0]  coord_y;
  logic [31:0] texel_value;
  logic [15:0] centre_u;
  logic [15:0] centre_v;
  logic [15:0] radius;
  logic [31:0] paint_colour;
  logic [11:0] opacity;
  modport source (output valid, action, coord_x, coord_y, texel_value, centre_u, centre_v,
                  radius, paint_colour, opacity, input ready);
  modport sink (input valid, action, coord_x, coord_y, texel_value, centre_u, centre_v,
                radius, paint_colour, opacity, output ready);
endinterface

interface bsb_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_value;
  logic        changed;
  modport source (output valid, read_value, changed, input ready);
  modport sink (input valid, read_value, changed, output ready);
endinterface

// File: design/brush_stamp_blender_unit.sv
// Texture painter with a radial falloff stamp. Texels and brush texels are loaded one per item
// and a read item returns one texel. A paint item walks the stamp's bounding box one texel at
// a time. A texel outside the circle needs two squarings on the shared arithmetic unit; one
// inside also needs the unit's 32-step square root and 13-step falloff divide and, with a brush
// image instead of a solid colour, two 24-step tiling divides, four brush reads and a bilinear
// blend of each channel. The texture and brush stores are plain memories with no clear; an
// entry must be written before it is read. One item is in work at a time; the result sits in
// an output register so the next item can be taken while it waits.
module brush_stamp_blender_unit import bsb_pkg::*; #(
  parameter int MAX_TEX_WIDTH    = DEF_MAX_TEX_WIDTH,
  parameter int MAX_TEX_HEIGHT   = DEF_MAX_TEX_HEIGHT,
  parameter int MAX_BRUSH_WIDTH  = DEF_MAX_BRUSH_WIDTH,
  parameter int MAX_BRUSH_HEIGHT = DEF_MAX_BRUSH_HEIGHT
) (
  input  logic clk,
  input  logic rst,
  bsb_cfg_if.sink      cfg,
  bsb_item_if.sink     item,
  bsb_result_if.source result
);

  localparam int TEX_DEPTH = MAX_TEX_WIDTH * MAX_TEX_HEIGHT;
  localparam int TEX_AW    = (TEX_DEPTH > 1) ? $clog2(TEX_DEPTH) : 1;
  localparam int BR_DEPTH  = MAX_BRUSH_WIDTH * MAX_BRUSH_HEIGHT;
  localparam int BR_AW     = (BR_DEPTH > 1) ? $clog2(BR_DEPTH) : 1;

  typedef enum logic [4:0] {
    S_IDLE, S_READ, S_SETUP1, S_SETUP2, S_RR_WAIT, S_BOX, S_DXY, S_MX, S_MX_WAIT,
    S_MY, S_MY_WAIT, S_TEST, S_SQ_WAIT, S_BNUM, S_BDIV, S_BDIV_WAIT, S_TU, S_TU_WAIT,
    S_TV, S_TV_WAIT, S_AXIS, S_BRA, S_BRB, S_BL1, S_BL2, S_TRD, S_TWR, S_NEXT, S_FIN
  } state_t;

  // configuration registers
  logic [8:0]  texture_width;
  logic [8:0]  texture_height;
  logic [2:0]  texture_channels;
  logic [6:0]  brush_width;
  logic [6:0]  brush_height;
  logic [2:0]  brush_channels;
  logic [15:0] brush_scale;

  logic [8:0] eff_w, eff_h;
  logic [2:0] eff_c, eff_bc;
  logic [6:0] eff_bw, eff_bh;
  logic       solid;

  state_t      state;
  logic [8:0]  x, y, xlo, xhi, ylo, yhi;
  logic [15:0] cu, cv;
  logic [15:0] radius_q;
  logic [31:0] colour;
  logic [11:0] op;
  logic [25:0] cx, cy;
  logic [27:0] r;
  logic [63:0] rr, d2, bnum;
  logic [25:0] dx, dy;
  logic [27:0] d;
  logic [8:0]  b;
  logic [15:0] tu, tv, fx, fy;
  logic [6:0]  bx0, bx1, by0, by1;
  logic [31:0] bt [4];
  logic [1:0]  k, ch;
  logic signed [25:0] top, bot;
  logic [3:0][7:0] src;
  logic        changed_acc;
  logic [31:0] read_acc;
  logic        out_valid;
  logic [31:0] out_read;
  logic        out_changed;

  arith_req_t arith_req;
  arith_rsp_t arith_rsp;

  logic item_fire;
  logic coord_in_tex, coord_in_brush;

  // memories
  logic [31:0]       tex_mem [TEX_DEPTH];
  logic [31:0]       br_mem [BR_DEPTH];
  logic              tex_we, br_we;
  logic [TEX_AW-1:0] tex_waddr, tex_raddr, tex_item_addr, tex_walk_addr;
  logic [BR_AW-1:0]  br_waddr, br_raddr;
  logic [31:0]       tex_wdata, tex_q, br_q, blended;

  // clamped register values
  always_comb begin
    eff_w  = (texture_width == 9'd0) ? 9'd1 :
             (int'(texture_width) > MAX_TEX_WIDTH) ? 9'(MAX_TEX_WIDTH) : texture_width;
    eff_h  = (texture_height == 9'd0) ? 9'd1 :
             (int'(texture_height) > MAX_TEX_HEIGHT) ? 9'(MAX_TEX_HEIGHT) : texture_height;
    eff_c  = (texture_channels == 3'd0) ? 3'd1 :
             (texture_channels > 3'd4) ? 3'd4 : texture_channels;
    eff_bw = (int'(brush_width) > MAX_BRUSH_WIDTH) ? 7'(MAX_BRUSH_WIDTH) : brush_width;
    eff_bh = (int'(brush_height) > MAX_BRUSH_HEIGHT) ? 7'(MAX_BRUSH_HEIGHT) : brush_height;
    eff_bc = (brush_channels == 3'd0) ? 3'd1 :
             (brush_channels > 3'd4) ? 3'd4 : brush_channels;
    solid  = (eff_bw == 7'd0) || (eff_bh == 7'd0);
  end

  // configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      texture_width    <= 9'd256;
      texture_height   <= 9'd256;
      texture_channels <= 3'd4;
      brush_width      <= 7'd0;
      brush_height     <= 7'd0;
      brush_channels   <= 3'd4;
      brush_scale      <= 16'd256;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_TEX_WIDTH:      texture_width    <= cfg.data[8:0];
        REG_TEX_HEIGHT:     texture_height   <= cfg.data[8:0];
        REG_TEX_CHANNELS:   texture_channels <= cfg.data[2:0];
        REG_BRUSH_WIDTH:    brush_width      <= cfg.data[6:0];
        REG_BRUSH_HEIGHT:   brush_height     <= cfg.data[6:0];
        REG_BRUSH_CHANNELS: brush_channels   <= cfg.data[2:0];
        REG_BRUSH_SCALE:    brush_scale      <= cfg.data;
        default: ;
      endcase
    end
  end

  assign item.ready = (state == S_IDLE);
  assign item_fire  = item.valid && item.ready;

  assign coord_in_tex   = ({1'b0, item.coord_x} < eff_w) && ({1'b0, item.coord_y} < eff_h);
  assign coord_in_brush = (item.coord_x < {1'b0, eff_bw}) && (item.coord_y < {1'b0, eff_bh});

  // bounding box of the stamp
  logic [28:0] cxw, cyw, rw, xlo_w, ylo_w, xhi_w, yhi_w;
  logic [8:0]  xlo_n, ylo_n, xhi_n, yhi_n;
  always_comb begin
    cxw   = {3'b0, cx};
    cyw   = {3'b0, cy};
    rw    = {1'b0, r};
    xlo_w = (cxw >= rw) ? (cxw - rw) : 29'd0;
    ylo_w = (cyw >= rw) ? (cyw - rw) : 29'd0;
    xhi_w = cxw + rw + 29'h0_FFFF;
    yhi_w = cyw + rw + 29'h0_FFFF;
    xlo_n = xlo_w[24:16];
    ylo_n = ylo_w[24:16];
    xhi_n = (xhi_w[28:16] > {4'b0, eff_w - 9'd1}) ? eff_w - 9'd1 : xhi_w[24:16];
    yhi_n = (yhi_w[28:16] > {4'b0, eff_h - 9'd1}) ? eff_h - 9'd1 : yhi_w[24:16];
  end

  // fixed-point position of the texel centre
  logic [25:0] px, py;
  always_comb begin
    px = {1'b0, x, 16'h8000};
    py = {1'b0, y, 16'h8000};
  end

  // tiling dividend for one axis
  logic [8:0]  tpos, tn;
  logic [25:0] tprod;
  logic [63:0] tnum;
  always_comb begin
    tpos  = (state == S_TU) ? x : y;
    tn    = (state == S_TU) ? eff_w : eff_h;
    tprod = {tpos, 1'b1} * brush_scale;
    tnum  = {30'b0, tprod, 8'b0} + {55'b0, tn};
  end

  // falloff dividend
  logic [39:0] bprod;
  assign bprod = (r - d) * op;

  // brush axis positions
  logic [23:0] pbx, pby;
  logic [7:0]  ibx, iby;
  logic [6:0]  ibx0, iby0;
  always_comb begin
    pbx  = tu * eff_bw + {1'b0, eff_bw, 16'h0} - 24'h8000;
    pby  = tv * eff_bh + {1'b0, eff_bh, 16'h0} - 24'h8000;
    ibx  = pbx[23:16];
    iby  = pby[23:16];
    ibx0 = (ibx >= {1'b0, eff_bw}) ? 7'(ibx - {1'b0, eff_bw}) : ibx[6:0];
    iby0 = (iby >= {1'b0, eff_bh}) ? 7'(iby - {1'b0, eff_bh}) : iby[6:0];
  end

  // bilinear taps for one channel
  logic [1:0]  sc;
  logic [7:0]  ta, tb, tc, te;
  logic signed [8:0]  dab, dce;
  logic signed [25:0] top_n, bot_n, dtb;
  logic signed [42:0] v;
  logic [42:0]        vr;
  always_comb begin
    sc = (ch == 2'd3) ? 2'd3 : ((ch < 2'(eff_bc - 3'd1)) ? ch : 2'(eff_bc - 3'd1));
    ta = bt[0][8*sc +: 8];
    tb = bt[1][8*sc +: 8];
    tc = bt[2][8*sc +: 8];
    te = bt[3][8*sc +: 8];
    dab   = $signed({1'b0, tb}) - $signed({1'b0, ta});
    dce   = $signed({1'b0, te}) - $signed({1'b0, tc});
    top_n = $signed({2'b00, ta, 16'h0000}) + dab * $signed({1'b0, fx});
    bot_n = $signed({2'b00, tc, 16'h0000}) + dce * $signed({1'b0, fx});
    dtb   = bot - top;
    v     = $signed({1'b0, top, 16'h0000}) + dtb * $signed({1'b0, fy});
    vr    = $unsigned(v) + 43'h0_8000_0000;
  end

  // blend of the fetched texel, lanes above the channel count pass through
  logic [16:0] lane_sum [4];
  always_comb begin
    blended = tex_q;
    for (int c = 0; c < 4; c++) begin
      lane_sum[c] = 17'(tex_q[8*c +: 8]) * 17'(9'd256 - b) + 17'(src[c]) * 17'(b) + 17'd128;
      if (3'(c) < eff_c) blended[8*c +: 8] = lane_sum[c][15:8];
    end
  end

  // requests to the shared unit
  always_comb begin
    arith_req = '0;
    case (state)
      S_SETUP2: begin
        arith_req.start = 1'b1;
        arith_req.op    = ARITH_MUL;
        arith_req.a     = {36'b0, r};
        arith_req.b     = {4'b0, r};
      end
      S_MX: begin
        arith_req.start = 1'b1;
        arith_req.op    = ARITH_MUL;
        arith_req.a     = {38'b0, dx};
        arith_req.b     = {6'b0, dx};
      end
      S_MY: begin
        arith_req.start = 1'b1;
        arith_req.op    = ARITH_MUL;
        arith_req.a     = {38'b0, dy};
        arith_req.b     = {6'b0, dy};
      end
      S_TEST: begin
        arith_req.start = (d2 <= rr);
        arith_req.op    = ARITH_SQRT;
        arith_req.a     = d2;
      end
      S_BDIV: begin
        arith_req.start = 1'b1;
        arith_req.op    = ARITH_DIV;
        arith_req.a     = bnum;
        arith_req.b     = {3'b0, r, 1'b0};
        arith_req.qbits = 5'd13;
      end
      S_TU, S_TV: begin
        arith_req.start = 1'b1;
        arith_req.op    = ARITH_DIV;
        arith_req.a     = tnum;
        arith_req.b     = {22'b0, tn, 1'b0};
        arith_req.qbits = 5'd24;
      end
      default: ;
    endcase
  end

  bsb_arith u_arith (
    .clk (clk),
    .rst (rst),
    .req (arith_req),
    .rsp (arith_rsp)
  );

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (result.valid && result.ready && state != S_FIN) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (item_fire) begin
            cu          <= item.centre_u;
            cv          <= item.centre_v;
            radius_q    <= item.radius;
            colour      <= item.paint_colour;
            op          <= item.opacity;
            read_acc    <= '0;
            changed_acc <= 1'b0;
            case (action_t'(item.action))
              ACT_PAINT: state <= S_SETUP1;
              ACT_READ:  state <= coord_in_tex ? S_READ : S_FIN;
              default:   state <= S_FIN;
            endcase
          end
        end
        S_READ: begin
          read_acc <= tex_q;
          state    <= S_FIN;
        end
        S_SETUP1: begin
          cx <= cu * eff_w;
          cy <= (17'h1_0000 - {1'b0, cv}) * eff_h;
          r  <= {radius_q, 12'h000};
          if (radius_q == 16'd0 || op == 12'd0) state <= S_FIN;
          else state <= S_SETUP2;
        end
        S_SETUP2: state <= S_RR_WAIT;
        S_RR_WAIT: begin
          if (arith_rsp.done) begin
            rr    <= arith_rsp.res;
            state <= S_BOX;
          end
        end
        S_BOX: begin
          xlo <= xlo_n;
          xhi <= xhi_n;
          ylo <= ylo_n;
          yhi <= yhi_n;
          x   <= xlo_n;
          y   <= ylo_n;
          if (xlo_n > xhi_n || ylo_n > yhi_n) state <= S_FIN;
          else state <= S_DXY;
        end
        S_DXY: begin
          dx    <= (px >= cx) ? px - cx : cx - px;
          dy    <= (py >= cy) ? py - cy : cy - py;
          state <= S_MX;
        end
        S_MX: state <= S_MX_WAIT;
        S_MX_WAIT: begin
          if (arith_rsp.done) begin
            d2    <= arith_rsp.res;
            state <= S_MY;
          end
        end
        S_MY: state <= S_MY_WAIT;
        S_MY_WAIT: begin
          if (arith_rsp.done) begin
            d2    <= d2 + arith_rsp.res;
            state <= S_TEST;
          end
        end
        S_TEST: state <= (d2 > rr) ? S_NEXT : S_SQ_WAIT;
        S_SQ_WAIT: begin
          if (arith_rsp.done) begin
            d     <= (arith_rsp.res > {36'b0, r}) ? r : arith_rsp.res[27:0];
            state <= S_BNUM;
          end
        end
        S_BNUM: begin
          bnum  <= {23'b0, bprod, 1'b0} + {36'b0, r};
          state <= S_BDIV;
        end
        S_BDIV: state <= S_BDIV_WAIT;
        S_BDIV_WAIT: begin
          if (arith_rsp.done) begin
            b <= (arith_rsp.res > 64'd256) ? 9'd256 : arith_rsp.res[8:0];
            if (solid) begin
              src   <= colour;
              state <= S_TRD;
            end else begin
              state <= S_TU;
            end
          end
        end
        S_TU: state <= S_TU_WAIT;
        S_TU_WAIT: begin
          if (arith_rsp.done) begin
            tu    <= arith_rsp.res[15:0];
            state <= S_TV;
          end
        end
        S_TV: state <= S_TV_WAIT;
        S_TV_WAIT: begin
          if (arith_rsp.done) begin
            tv    <= arith_rsp.res[15:0];
            state <= S_AXIS;
          end
        end
        S_AXIS: begin
          bx0   <= ibx0;
          bx1   <= (ibx0 + 7'd1 == eff_bw) ? 7'd0 : ibx0 + 7'd1;
          by0   <= iby0;
          by1   <= (iby0 + 7'd1 == eff_bh) ? 7'd0 : iby0 + 7'd1;
          fx    <= pbx[15:0];
          fy    <= pby[15:0];
          k     <= 2'd0;
          state <= S_BRA;
        end
        S_BRA: state <= S_BRB;
        S_BRB: begin
          bt[k] <= br_q;
          if (k == 2'd3) begin
            ch    <= 2'd0;
            state <= S_BL1;
          end else begin
            k     <= k + 2'd1;
            state <= S_BRA;
          end
        end
        S_BL1: begin
          if (ch == 2'd3 && eff_bc < 3'd4) begin
            src[3] <= 8'hFF;
            state  <= S_TRD;
          end else begin
            top   <= top_n;
            bot   <= bot_n;
            state <= S_BL2;
          end
        end
        S_BL2: begin
          src[ch] <= vr[39:32];
          if (ch == 2'd3) begin
            state <= S_TRD;
          end else begin
            ch    <= ch + 2'd1;
            state <= S_BL1;
          end
        end
        S_TRD: state <= S_TWR;
        S_TWR: begin
          changed_acc <= 1'b1;
          state       <= S_NEXT;
        end
        S_NEXT: begin
          if (x == xhi) begin
            x <= xlo;
            if (y == yhi) begin
              state <= S_FIN;
            end else begin
              y     <= y + 9'd1;
              state <= S_DXY;
            end
          end else begin
            x     <= x + 9'd1;
            state <= S_DXY;
          end
        end
        S_FIN: begin
          if (!out_valid || result.ready) begin
            out_valid   <= 1'b1;
            out_read    <= read_acc;
            out_changed <= changed_acc;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // store addressing
  logic [1:0] kb;
  always_comb begin
    tex_item_addr = TEX_AW'(int'(item.coord_y) * MAX_TEX_WIDTH + int'(item.coord_x));
    tex_walk_addr = TEX_AW'(int'(y) * MAX_TEX_WIDTH + int'(x));
    tex_raddr     = (state == S_IDLE) ? tex_item_addr : tex_walk_addr;
    tex_we        = (item_fire && action_t'(item.action) == ACT_TEX_WRITE && coord_in_tex) ||
                    (state == S_TWR);
    tex_waddr     = (state == S_TWR) ? tex_walk_addr : tex_item_addr;
    tex_wdata     = (state == S_TWR) ? blended : item.texel_value;
    br_we         = item_fire && action_t'(item.action) == ACT_BRUSH_WRITE && coord_in_brush;
    br_waddr      = BR_AW'(int'(item.coord_y) * MAX_BRUSH_WIDTH + int'(item.coord_x));
    kb            = k;
    case (kb)
      2'd0:    br_raddr = BR_AW'(int'(by0) * MAX_BRUSH_WIDTH + int'(bx0));
      2'd1:    br_raddr = BR_AW'(int'(by0) * MAX_BRUSH_WIDTH + int'(bx1));
      2'd2:    br_raddr = BR_AW'(int'(by1) * MAX_BRUSH_WIDTH + int'(bx0));
      default: br_raddr = BR_AW'(int'(by1) * MAX_BRUSH_WIDTH + int'(bx1));
    endcase
  end

  // texture store
  always_ff @(posedge clk) begin
    if (tex_we) tex_mem[tex_waddr] <= tex_wdata;
    tex_q <= tex_mem[tex_raddr];
  end

  // brush store
  always_ff @(posedge clk) begin
    if (br_we) br_mem[br_waddr] <= item.texel_value;
    br_q <= br_mem[br_raddr];
  end

  // result channel
  assign result.valid      = out_valid;
  assign result.read_value = out_read;
  assign result.changed    = out_changed;

`ifndef SYNTHESIS
  // an accepted item always makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_fire |=> !item.ready)
    else $error("ready stayed high after an item transfer");

  // a read never reports a change and a paint never returns texel data
  a_result_exclusive: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.changed && result.read_value != 32'd0))
    else $error("result carries both a change flag and read data");

  // the shared unit is only started when it is free
  a_arith_free: assert property (@(posedge clk) disable iff (rst)
    arith_req.start |-> arith_rsp.idle)
    else $error("shared unit started while busy");

  // the walk stays inside the bounding box
  a_walk_in_box: assert property (@(posedge clk) disable iff (rst)
    (state == S_DXY) |-> (x >= xlo && x <= xhi && y >= ylo && y <= yhi))
    else $error("texel walk left the bounding box");

  // the blend weight never exceeds one
  a_blend_weight: assert property (@(posedge clk) disable iff (rst)
    (state == S_TWR) |-> (b <= 9'd256))
    else $error("blend weight above one");
`endif

endmodule

// File: design/bsb_arith.sv
module bsb_arith import bsb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  arith_req_t req,
  output arith_rsp_t rsp
);

  typedef enum logic [1:0] {U_IDLE, U_DIV, U_SQRT, U_DONE} ustate_t;

  ustate_t     state;
  logic [63:0] rem;
  logic [63:0] acc;
  logic [63:0] step;
  logic [5:0]  count;
  logic [63:0] trial;
  logic        fits;
  logic [63:0] prod;

  // one compare and subtract serves both the divider and the root
  always_comb begin
    trial = (state == U_SQRT) ? acc + step : step;
    fits  = rem >= trial;
    prod  = req.a[31:0] * req.b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
    end else begin
      case (state)
        U_IDLE: begin
          if (req.start) begin
            case (req.op)
              ARITH_MUL: begin
                acc   <= prod;
                state <= U_DONE;
              end
              ARITH_DIV: begin
                rem   <= req.a;
                acc   <= '0;
                step  <= {32'b0, req.b} << (req.qbits - 5'd1);
                count <= {1'b0, req.qbits};
                state <= U_DIV;
              end
              ARITH_SQRT: begin
                rem   <= req.a;
                acc   <= '0;
                step  <= 64'h4000_0000_0000_0000;
                count <= 6'd32;
                state <= U_SQRT;
              end
              default: state <= U_DONE;
            endcase
          end
        end
        // restoring divide, one quotient bit per cycle
        U_DIV: begin
          if (fits) begin
            rem <= rem - trial;
            acc <= {acc[62:0], 1'b1};
          end else begin
            acc <= {acc[62:0], 1'b0};
          end
          step  <= step >> 1;
          count <= count - 6'd1;
          if (count == 6'd1) state <= U_DONE;
        end
        // digit by digit square root, one root bit per cycle
        U_SQRT: begin
          if (fits) begin
            rem <= rem - trial;
            acc <= (acc >> 1) + step;
          end else begin
            acc <= acc >> 1;
          end
          step  <= step >> 2;
          count <= count - 6'd1;
          if (count == 6'd1) state <= U_DONE;
        end
        U_DONE: state <= U_IDLE;
        default: state <= U_IDLE;
      endcase
    end
  end

  assign rsp.idle = (state == U_IDLE);
  assign rsp.done = (state == U_DONE);
  assign rsp.res  = acc;

endmodule
